// File: rtl/core/rcsd_pkg.sv
// Shared types and constants for the clipped RLE8 span decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rcsd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_DST_LEFT    = 3'd0;
    localparam logic [2:0] REG_DST_BOTTOM  = 3'd1;
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd2;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd3;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd4;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd5;

    // A zero count byte introduces an escape; the next byte picks which one.
    localparam logic [7:0] RLE_ESCAPE = 8'd0;
    localparam logic [7:0] ESC_EOL    = 8'd0;
    localparam logic [7:0] ESC_EOB    = 8'd1;
    localparam logic [7:0] ESC_DELTA  = 8'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [15:0] dst_left;
        logic signed [15:0] dst_bottom;
        logic [14:0]        clip_left;
        logic [14:0]        clip_right;
        logic [14:0]        clip_top;
        logic [14:0]        clip_bottom;
    } cfg_t;

    // One span word. Between front and back, len is the unclipped run length.
    typedef struct packed {
        logic               done;
        logic signed [15:0] row;
        logic signed [15:0] x;
        logic [7:0]         len;
        logic [7:0]         value;
    } span_t;

endpackage
`default_nettype wire

// File: rtl/core/rle8_clipped_span_decoder_top.sv
// Top level of the clipped RLE8 span decoder: configuration registers,
// front end, word queue and back end. Depends on rcsd_pkg, rcsd_front, rcsd_queue, rcsd_back.
//
// Bytes of a BI_RLE8 stream enter through push/full, one per cycle while full is low, and span
// writes (row, x, len, value) or a final done word leave through empty/pop.
// The front end decodes one byte per clock while full is low and passes unclipped runs into a
// four-word queue; the back end clips one run per clock while the result queue has room into a
// four-word result queue, so the block sustains one byte per cycle while results are taken, and
// a result passes through the run queue and then the result queue after the byte that caused it.
// full rises only when the run queue is full. Configuration writes through
// wr_en/wr_index/wr_data take effect at the next clock and should be made
// while no words are in flight.
`default_nettype none
module rle8_clipped_span_decoder_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [2:0]         wr_index,
    input  wire logic [15:0]        wr_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         rle_byte,
    input  wire logic               first,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      span_row,
    output logic signed [15:0]      span_x,
    output logic [7:0]              span_len,
    output logic [7:0]              span_value,
    output logic                    done_res
);
    import rcsd_pkg::*;

    cfg_t  cfg_reg;
    logic  accept;
    logic  cmd_push;
    span_t cmd_in;
    logic  cmd_full;
    logic  cmd_pop;
    span_t cmd_out;
    logic  cmd_empty;
    span_t res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DST_LEFT:    cfg_reg.dst_left    <= wr_data;
                REG_DST_BOTTOM:  cfg_reg.dst_bottom  <= wr_data;
                REG_CLIP_LEFT:   cfg_reg.clip_left   <= wr_data[14:0];
                REG_CLIP_RIGHT:  cfg_reg.clip_right  <= wr_data[14:0];
                REG_CLIP_TOP:    cfg_reg.clip_top    <= wr_data[14:0];
                REG_CLIP_BOTTOM: cfg_reg.clip_bottom <= wr_data[14:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    rcsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .rle_byte (rle_byte),
        .first    (first),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in)
    );

    rcsd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    rcsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_data  (res_data),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign span_row   = res_data.row;
    assign span_x     = res_data.x;
    assign span_len   = res_data.len;
    assign span_value = res_data.value;
    assign done_res   = res_data.done;

endmodule
`default_nettype wire

// File: rtl/core/rcsd_queue.sv
// Small first-in first-out queue of span words.
// Depends on rcsd_pkg for the word type and depth.
`default_nettype none
module rcsd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  rcsd_pkg::span_t    push_data,
    output logic               full,
    input  wire logic          pop,
    output rcsd_pkg::span_t    pop_data,
    output logic               empty
);
    import rcsd_pkg::*;

    span_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/rcsd_front.sv
// Front end: parses the RLE8 byte stream and tracks the drawing position.
// Emits unclipped span words and done words; depends on rcsd_pkg.
`default_nettype none
module rcsd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  rcsd_pkg::cfg_t     cfg,
    input  wire logic          accept,
    input  wire logic [7:0]    rle_byte,
    input  wire logic          first,
    output logic               cmd_push,
    output rcsd_pkg::span_t    cmd_data
);
    import rcsd_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_VALUE = 3'd2;
    localparam logic [2:0] PH_ESC   = 3'd3;
    localparam logic [2:0] PH_DX    = 3'd4;
    localparam logic [2:0] PH_DY    = 3'd5;
    localparam logic [2:0] PH_LIT   = 3'd6;
    localparam logic [2:0] PH_PAD   = 3'd7;

    logic [2:0]  phase_reg,    phase_next;
    logic [15:0] cur_x_reg,    cur_x_next;
    logic [15:0] cur_row_reg,  cur_row_next;
    logic [7:0]  held_reg,     held_next;
    logic [7:0]  lit_left_reg, lit_left_next;
    logic        pad_reg,      pad_next;
    logic        finished_reg, finished_next;

    logic [2:0]  eff_phase;
    logic [15:0] eff_x;
    logic [15:0] eff_row;
    logic        eff_finished;
    logic [15:0] start_row;
    logic [15:0] row_dec;
    logic [15:0] row_sub;
    logic [7:0]  lit_dec;
    logic        start_below;
    logic        dec_below;
    logic        sub_below;

    assign start_row   = cfg.dst_bottom - 16'd1;
    assign eff_phase   = first ? PH_COUNT : phase_reg;
    assign eff_x       = first ? cfg.dst_left : cur_x_reg;
    assign eff_row     = first ? start_row : cur_row_reg;
    assign eff_finished = first ? 1'b0 : finished_reg;
    assign row_dec     = eff_row - 16'd1;
    assign row_sub     = eff_row - {8'd0, rle_byte};
    assign lit_dec     = lit_left_reg - 8'd1;
    assign start_below = $signed(start_row) < $signed({1'b0, cfg.clip_top});
    assign dec_below   = $signed(row_dec) < $signed({1'b0, cfg.clip_top});
    assign sub_below   = $signed(row_sub) < $signed({1'b0, cfg.clip_top});

    always_comb
    begin
        phase_next    = phase_reg;
        cur_x_next    = cur_x_reg;
        cur_row_next  = cur_row_reg;
        held_next     = held_reg;
        lit_left_next = lit_left_reg;
        pad_next      = pad_reg;
        finished_next = finished_reg;
        cmd_push      = 1'b0;
        cmd_data      = '0;
        if (accept)
        begin
            if (first)
            begin
                phase_next    = PH_COUNT;
                cur_x_next    = eff_x;
                cur_row_next  = eff_row;
                held_next     = '0;
                lit_left_next = '0;
                pad_next      = 1'b0;
                finished_next = 1'b0;
            end
            if (first && start_below)
            begin
                phase_next    = PH_IDLE;
                finished_next = 1'b1;
                cmd_push      = 1'b1;
                cmd_data.done = 1'b1;
            end
            else if (!eff_finished)
            begin
                unique case (eff_phase)
                    PH_COUNT:
                    begin
                        if (rle_byte == RLE_ESCAPE)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            held_next  = rle_byte;
                            phase_next = PH_VALUE;
                        end
                    end
                    PH_VALUE:
                    begin
                        phase_next     = PH_COUNT;
                        cur_x_next     = eff_x + {8'd0, held_reg};
                        cmd_push       = (rle_byte != 8'd0);
                        cmd_data.row   = eff_row;
                        cmd_data.x     = eff_x;
                        cmd_data.len   = held_reg;
                        cmd_data.value = rle_byte;
                    end
                    PH_ESC:
                    begin
                        priority if (rle_byte == ESC_EOL)
                        begin
                            cur_row_next = row_dec;
                            cur_x_next   = cfg.dst_left;
                            phase_next   = PH_COUNT;
                            if (dec_below)
                            begin
                                phase_next    = PH_IDLE;
                                finished_next = 1'b1;
                                cmd_push      = 1'b1;
                                cmd_data.done = 1'b1;
                            end
                        end
                        else if (rle_byte == ESC_EOB)
                        begin
                            phase_next    = PH_IDLE;
                            finished_next = 1'b1;
                            cmd_push      = 1'b1;
                            cmd_data.done = 1'b1;
                        end
                        else if (rle_byte == ESC_DELTA)
                        begin
                            phase_next = PH_DX;
                        end
                        else
                        begin
                            lit_left_next = rle_byte;
                            pad_next      = rle_byte[0];
                            phase_next    = PH_LIT;
                        end
                    end
                    PH_DX:
                    begin
                        cur_x_next = eff_x + {8'd0, rle_byte};
                        phase_next = PH_DY;
                    end
                    PH_DY:
                    begin
                        cur_row_next = row_sub;
                        phase_next   = PH_COUNT;
                        if (sub_below)
                        begin
                            phase_next    = PH_IDLE;
                            finished_next = 1'b1;
                            cmd_push      = 1'b1;
                            cmd_data.done = 1'b1;
                        end
                    end
                    PH_LIT:
                    begin
                        cur_x_next    = eff_x + 16'd1;
                        lit_left_next = lit_dec;
                        if (lit_dec == 8'd0)
                        begin
                            phase_next = pad_reg ? PH_PAD : PH_COUNT;
                        end
                        // A literal pixel is a run of one and is clipped the same way.
                        cmd_push       = (rle_byte != 8'd0);
                        cmd_data.row   = eff_row;
                        cmd_data.x     = eff_x;
                        cmd_data.len   = 8'd1;
                        cmd_data.value = rle_byte;
                    end
                    PH_PAD:
                    begin
                        pad_next   = 1'b0;
                        phase_next = PH_COUNT;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cur_x_reg    <= '0;
            cur_row_reg  <= '0;
            held_reg     <= '0;
            lit_left_reg <= '0;
            pad_reg      <= 1'b0;
            finished_reg <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            cur_x_reg    <= cur_x_next;
            cur_row_reg  <= cur_row_next;
            held_reg     <= held_next;
            lit_left_reg <= lit_left_next;
            pad_reg      <= pad_next;
            finished_reg <= finished_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/rcsd_back.sv
// Back end: clips span words against the window and queues the results.
// Depends on rcsd_pkg and rcsd_queue.
`default_nettype none
module rcsd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  rcsd_pkg::cfg_t     cfg,
    input  wire logic          cmd_empty,
    input  rcsd_pkg::span_t    cmd_data,
    output logic               cmd_pop,
    output rcsd_pkg::span_t    res_data,
    output logic               res_empty,
    input  wire logic          res_pop
);
    import rcsd_pkg::*;

    logic signed [16:0] x_start;
    logic signed [16:0] x_end;
    logic signed [16:0] lim_left;
    logic signed [16:0] lim_right;
    logic signed [16:0] s_col;
    logic signed [16:0] e_col;
    logic signed [16:0] width;
    logic               row_ok;
    logic               visible;
    logic               res_full;
    logic               res_push;
    span_t              res_word;

    // Column limits are worked out in 17 bits so distances never wrap.
    assign x_start   = {cmd_data.x[15], cmd_data.x};
    assign x_end     = x_start + $signed({9'd0, cmd_data.len});
    assign lim_left  = $signed({2'b00, cfg.clip_left});
    assign lim_right = $signed({2'b00, cfg.clip_right});
    assign s_col     = (x_start > lim_left) ? x_start : lim_left;
    assign e_col     = (x_end < lim_right) ? x_end : lim_right;
    assign width     = e_col - s_col;
    assign row_ok    = cmd_data.row < $signed({1'b0, cfg.clip_bottom});
    assign visible   = row_ok && (e_col > s_col);

    always_comb
    begin
        res_word = '0;
        if (cmd_data.done)
        begin
            res_word.done = 1'b1;
        end
        else
        begin
            res_word.row   = cmd_data.row;
            res_word.x     = s_col[15:0];
            res_word.len   = width[7:0];
            res_word.value = cmd_data.value;
        end
    end

    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop && (cmd_data.done || visible);

    rcsd_queue u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_word),
        .full      (res_full),
        .pop       (res_pop),
        .pop_data  (res_data),
        .empty     (res_empty)
    );

endmodule
`default_nettype wire
